>>> rtl/core/hid_pressed_key_table_macros.svh
// assertion helpers used by the key table controller
`ifndef HID_PRESSED_KEY_TABLE_MACROS_SVH
`define HID_PRESSED_KEY_TABLE_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define HPKT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define HPKT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/core/hpkt_pkg.sv
package hpkt_pkg;

    // report geometry
    localparam int SLOTS  = 6;
    localparam int SLOT_W = 3;

    // repeat counter saturation
    localparam logic [7:0] REPEAT_MAX = 8'hFF;

    // command modes
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_TAP     = 2'd2;
    localparam logic [1:0] MODE_REPORT  = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_PRESENT   = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [7:0] code;
        logic       tapped;
        logic [7:0] repeats;
    } hpkt_entry_t;

    localparam int ENTRY_W = $bits(hpkt_entry_t);

    // key codes of one report, slot 0 first
    typedef logic [SLOTS-1:0][7:0] hpkt_slots_t;

    // command beat
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] key_code;
        logic [7:0] modifier_bits;
    } hpkt_in_t;

    // result beat
    typedef struct packed {
        logic [1:0] status;
        logic       is_report;
        logic [7:0] report_modifiers;
        logic [7:0] slot0;
        logic [7:0] slot1;
        logic [7:0] slot2;
        logic [7:0] slot3;
        logic [7:0] slot4;
        logic [7:0] slot5;
        logic       more_pending;
        logic       last;
    } hpkt_out_t;

endpackage

>>> rtl/core/hpkt_ram.sv
module hpkt_ram #(
    parameter int WIDTH  = 17,
    parameter int DEPTH  = 6,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/hpkt_ctrl.sv
`include "hid_pressed_key_table_macros.svh"

module hpkt_ctrl
    import hpkt_pkg::*;
#(
    parameter int MAX_KEYS = 6,
    parameter int ADDR_W   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
    parameter int CNT_W    = $clog2(MAX_KEYS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  hpkt_in_t          cmd,
    input  logic [7:0]        none_code,
    output logic              busy,
    output hpkt_out_t         result,
    output logic              strobe,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output hpkt_entry_t       ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  hpkt_entry_t       ram_rdata
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_FIND_RD  = 11'b000_0000_0010,
        S_FIND_CHK = 11'b000_0000_0100,
        S_DOWN_RD  = 11'b000_0000_1000,
        S_DOWN_WR  = 11'b000_0001_0000,
        S_UP_RD    = 11'b000_0010_0000,
        S_UP_WR    = 11'b000_0100_0000,
        S_INS      = 11'b000_1000_0000,
        S_REP_RD   = 11'b001_0000_0000,
        S_REP_WR   = 11'b010_0000_0000,
        S_OUT2     = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  wr_reg, wr_next;
    logic [SLOT_W-1:0] nb_reg, nb_next;
    logic              any_tap_reg, any_tap_next;
    logic              pend_reg, pend_next;
    logic [1:0]        mode_reg, mode_next;
    logic [7:0]        key_reg, key_next;
    logic [7:0]        mods_reg, mods_next;
    logic              tap_reg, tap_next;
    hpkt_slots_t       rep_a_reg, rep_a_next;
    hpkt_slots_t       rep_b_reg, rep_b_next;
    hpkt_out_t         res_reg, res_next;
    logic              strobe_reg, strobe_next;

    logic [CNT_W-1:0]  idx_dec;
    logic              hit;
    hpkt_entry_t       upd;

    // status result beat
    function automatic hpkt_out_t status_beat(input logic [1:0] st);
        hpkt_out_t b;
        b        = '0;
        b.status = st;
        b.last   = 1'b1;
        return b;
    endfunction

    // report result beat
    function automatic hpkt_out_t report_beat(input logic [7:0] mods, input hpkt_slots_t s,
                                              input logic more, input logic fin);
        hpkt_out_t b;
        b                  = '0;
        b.is_report        = 1'b1;
        b.report_modifiers = mods;
        b.slot0            = s[0];
        b.slot1            = s[1];
        b.slot2            = s[2];
        b.slot3            = s[3];
        b.slot4            = s[4];
        b.slot5            = s[5];
        b.more_pending     = more;
        b.last             = fin;
        return b;
    endfunction

    assign idx_dec = idx_reg - 1'b1;
    assign hit     = (ram_rdata.code == key_reg);

    // sequencer: scan the table one entry per read, shift and compact it one entry per read/write pair
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        wr_next      = wr_reg;
        nb_next      = nb_reg;
        any_tap_next = any_tap_reg;
        pend_next    = pend_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        mods_next    = mods_reg;
        tap_next     = tap_reg;
        rep_a_next   = rep_a_reg;
        rep_b_next   = rep_b_reg;
        res_next     = res_reg;
        strobe_next  = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        upd          = ram_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = cmd.mode;
                    key_next  = cmd.key_code;
                    mods_next = cmd.modifier_bits;
                    tap_next  = (cmd.mode == MODE_TAP) || (cmd.key_code == none_code);
                    idx_next  = '0;
                    if (cmd.mode == MODE_REPORT)
                    begin
                        rep_a_next   = '0;
                        rep_b_next   = '0;
                        nb_next      = '0;
                        wr_next      = '0;
                        any_tap_next = 1'b0;
                        pend_next    = 1'b0;
                        state_next   = S_REP_RD;
                    end
                    else
                    begin
                        state_next = S_FIND_RD;
                    end
                end
            end

            // look for the key, one entry per read
            S_FIND_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (mode_reg == MODE_RELEASE)
                    begin
                        res_next    = status_beat(STAT_NOT_FOUND);
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (count_reg >= CNT_W'(MAX_KEYS))
                    begin
                        res_next    = status_beat(STAT_FULL);
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        state_next = S_UP_RD;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[ADDR_W-1:0];
                    state_next = S_FIND_CHK;
                end
            end

            S_FIND_CHK:
            begin
                if (hit)
                begin
                    if (mode_reg == MODE_RELEASE)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DOWN_RD;
                    end
                    else
                    begin
                        // repeat tap or change of kind on a present key
                        if (ram_rdata.tapped && tap_reg)
                        begin
                            if (ram_rdata.repeats != REPEAT_MAX)
                            begin
                                upd.repeats = ram_rdata.repeats + 1'b1;
                            end
                        end
                        else
                        begin
                            upd.tapped  = tap_reg;
                            upd.repeats = '0;
                        end
                        ram_we      = 1'b1;
                        ram_waddr   = idx_reg[ADDR_W-1:0];
                        ram_wdata   = upd;
                        res_next    = status_beat(STAT_PRESENT);
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end

            // close the gap left by a release
            S_DOWN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next  = count_reg - 1'b1;
                    res_next    = status_beat(STAT_OK);
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[ADDR_W-1:0];
                    state_next = S_DOWN_WR;
                end
            end

            S_DOWN_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_dec[ADDR_W-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = S_DOWN_RD;
            end

            // open slot zero for a new key, moving entries up from the tail
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_dec[ADDR_W-1:0];
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[ADDR_W-1:0];
                idx_next   = idx_dec;
                state_next = S_UP_RD;
            end

            S_INS:
            begin
                upd.code    = key_reg;
                upd.tapped  = tap_reg;
                upd.repeats = '0;
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = upd;
                count_next  = count_reg + 1'b1;
                res_next    = status_beat(STAT_OK);
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end

            // report pass: read each entry, write back the compacted table
            S_REP_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next  = wr_reg;
                    strobe_next = 1'b1;
                    if (any_tap_reg)
                    begin
                        res_next   = report_beat(mods_reg, rep_a_reg, 1'b0, 1'b0);
                        state_next = S_OUT2;
                    end
                    else
                    begin
                        res_next   = report_beat(mods_reg, rep_a_reg, pend_reg, 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[ADDR_W-1:0];
                    state_next = S_REP_WR;
                end
            end

            S_REP_WR:
            begin
                rep_a_next[SLOT_W'(idx_reg)] = ram_rdata.code;
                if (ram_rdata.tapped && (ram_rdata.repeats == '0))
                begin
                    // exhausted tap drops out
                    any_tap_next = 1'b1;
                end
                else
                begin
                    if (ram_rdata.tapped)
                    begin
                        upd.repeats  = ram_rdata.repeats - 1'b1;
                        any_tap_next = 1'b1;
                        pend_next    = 1'b1;
                    end
                    else
                    begin
                        rep_b_next[nb_reg] = ram_rdata.code;
                        nb_next            = nb_reg + 1'b1;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg[ADDR_W-1:0];
                    ram_wdata = upd;
                    wr_next   = wr_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_REP_RD;
            end

            // second report with held keys only
            S_OUT2:
            begin
                res_next    = report_beat(mods_reg, rep_b_reg, pend_reg, 1'b1);
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
            idx_reg     <= '0;
            wr_reg      <= '0;
            nb_reg      <= '0;
            any_tap_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            strobe_reg  <= strobe_next;
            idx_reg     <= idx_next;
            wr_reg      <= wr_next;
            nb_reg      <= nb_next;
            any_tap_reg <= any_tap_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        mods_reg  <= mods_next;
        tap_reg   <= tap_next;
        rep_a_reg <= rep_a_next;
        rep_b_reg <= rep_b_next;
        res_reg   <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign result = res_reg;
    assign strobe = strobe_reg;

    `HPKT_ASSERT(a_last_in_idle, clk, rst_n, strobe_reg && res_reg.last |-> state_reg == S_IDLE, "final beat while sequencer still running")
    `HPKT_ASSERT(a_first_then_out2, clk, rst_n, strobe_reg && !res_reg.last |-> state_reg == S_OUT2, "first report beat without second pending")
    `HPKT_ASSERT(a_accept_busy, clk, rst_n, start && state_reg == S_IDLE |=> state_reg != S_IDLE, "accepted command did not start the sequencer")
    `HPKT_NEVER(a_idle_no_write, clk, rst_n, state_reg == S_IDLE && ram_we, "table write while idle")
    `HPKT_ASSERT(a_chk_after_read, clk, rst_n, state_reg == S_FIND_CHK |-> $past(ram_re), "compare without a preceding table read")

endmodule

>>> rtl/core/hid_pressed_key_table.sv
// a press or tap of a new key scans the whole table, then moves entries up to free slot zero;
//   a repeated key stops at its match; a release scans to the key and moves later entries down;
//   a report passes over every entry; each result beat appears in the cycle after it is formed
// throughput: one command at a time; a new command is taken only in idle, while busy is low
// reset clears entry count, pending flag, none code and result strobe; table ram is not cleared
// results are strobed for one cycle and cannot be stalled by the receiver
module hid_pressed_key_table
    import hpkt_pkg::*;
#(
    parameter int MAX_KEYS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  hpkt_in_t   cmd,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output hpkt_out_t  result,
    output logic       strobe
);

    localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    logic [7:0]        none_code_reg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    hpkt_entry_t       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    hpkt_entry_t       ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_bits;

    // none key code register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            none_code_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            none_code_reg <= cfg_wr_data;
        end
    end

    // table storage
    hpkt_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (MAX_KEYS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = hpkt_entry_t'(ram_rdata_bits);

    // command sequencer
    hpkt_ctrl #(
        .MAX_KEYS (MAX_KEYS),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .none_code (none_code_reg),
        .busy      (busy),
        .result    (result),
        .strobe    (strobe),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

>>> test/tb_hid_pressed_key_table.sv
`timescale 1ns / 100ps

module tb_hid_pressed_key_table;
    import hpkt_pkg::*;

    localparam int TABLE_KEYS = 6;
    localparam logic [1:0] MODE_PRESS = 2'd0;
    localparam time RUN_LIMIT = 5_000_000ns;

    // key table model plus the queue of result beats it still owes
    class key_table_checker;
        logic [7:0] none_code;
        logic [7:0] key_at [TABLE_KEYS];
        bit         tap_at [TABLE_KEYS];
        logic [7:0] repeats_at [TABLE_KEYS];
        int         key_count;
        bit         more_flag;
        hpkt_out_t  owed_beats [$];
        int         errors;
        int         beats_checked;
        int         full_hits;
        int         saturated_hits;
        int         two_beat_reports;
        int         mode_hits [4];

        function new();
            none_code = 8'h00;
            key_count = 0;
            more_flag = 1'b0;
            errors = 0;
            beats_checked = 0;
            full_hits = 0;
            saturated_hits = 0;
            two_beat_reports = 0;
            foreach (mode_hits[i]) mode_hits[i] = 0;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        function int find_key(logic [7:0] k);
            for (int i = 0; i < key_count; i++)
                if (key_at[i] == k)
                    return i;
            return -1;
        endfunction

        // remove one entry, closing the gap
        function void drop_key(int pos);
            for (int i = pos; i + 1 < key_count; i++)
            begin
                key_at[i] = key_at[i + 1];
                tap_at[i] = tap_at[i + 1];
                repeats_at[i] = repeats_at[i + 1];
            end
            if (key_count > 0)
                key_count--;
        endfunction

        function hpkt_out_t build_report(logic [7:0] mods, bit with_taps);
            hpkt_out_t   r;
            hpkt_slots_t s;
            int          n;
            r = '0;
            s = '0;
            n = 0;
            for (int i = 0; i < key_count; i++)
                if (!tap_at[i] || with_taps)
                begin
                    s[n] = key_at[i];
                    n++;
                end
            r.status = STAT_OK;
            r.is_report = 1'b1;
            r.report_modifiers = mods;
            r.slot0 = s[0];
            r.slot1 = s[1];
            r.slot2 = s[2];
            r.slot3 = s[3];
            r.slot4 = s[4];
            r.slot5 = s[5];
            return r;
        endfunction

        // update the table for an accepted command and queue its beats
        function void apply_command(hpkt_in_t c);
            hpkt_out_t r1;
            hpkt_out_t r2;
            bit        any_tap;
            bit        tap;
            int        pos;
            int        i;
            mode_hits[c.mode]++;
            r1 = '0;
            r1.last = 1'b1;
            case (c.mode)
                MODE_REPORT:
                begin
                    r1 = build_report(c.modifier_bits, 1'b1);
                    any_tap = 1'b0;
                    more_flag = 1'b0;
                    i = 0;
                    // exhausted taps leave, the others count down
                    while (i < key_count)
                    begin
                        if (tap_at[i] && repeats_at[i] == 8'd0)
                        begin
                            drop_key(i);
                            any_tap = 1'b1;
                        end
                        else
                        begin
                            if (tap_at[i])
                            begin
                                repeats_at[i]--;
                                any_tap = 1'b1;
                                more_flag = 1'b1;
                            end
                            i++;
                        end
                    end
                    if (!any_tap)
                    begin
                        r1.more_pending = more_flag;
                        r1.last = 1'b1;
                        owed_beats.push_back(r1);
                    end
                    else
                    begin
                        owed_beats.push_back(r1);
                        r2 = build_report(c.modifier_bits, 1'b0);
                        r2.more_pending = more_flag;
                        r2.last = 1'b1;
                        owed_beats.push_back(r2);
                        two_beat_reports++;
                    end
                end
                MODE_RELEASE:
                begin
                    pos = find_key(c.key_code);
                    if (pos < 0)
                        r1.status = STAT_NOT_FOUND;
                    else
                    begin
                        drop_key(pos);
                        r1.status = STAT_OK;
                    end
                    owed_beats.push_back(r1);
                end
                default:
                begin
                    tap = (c.mode == MODE_TAP) || (c.key_code == none_code);
                    pos = find_key(c.key_code);
                    if (pos >= 0)
                    begin
                        // repeat tap counts up, anything else resets the kind
                        if (tap_at[pos] && tap)
                        begin
                            if (repeats_at[pos] != REPEAT_MAX)
                                repeats_at[pos]++;
                            else
                                saturated_hits++;
                        end
                        else
                        begin
                            tap_at[pos] = tap;
                            repeats_at[pos] = 8'd0;
                        end
                        r1.status = STAT_PRESENT;
                    end
                    else if (key_count >= TABLE_KEYS)
                    begin
                        r1.status = STAT_FULL;
                        full_hits++;
                    end
                    else
                    begin
                        for (i = key_count; i > 0; i--)
                        begin
                            key_at[i] = key_at[i - 1];
                            tap_at[i] = tap_at[i - 1];
                            repeats_at[i] = repeats_at[i - 1];
                        end
                        key_at[0] = c.key_code;
                        tap_at[0] = tap;
                        repeats_at[0] = 8'd0;
                        key_count++;
                        r1.status = STAT_OK;
                    end
                    owed_beats.push_back(r1);
                end
            endcase
        endfunction

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("beat %0d field %s: got %h, expected %h",
                                 beats_checked, name, got, want));
        endtask

        task check_beat(hpkt_out_t got);
            hpkt_out_t want;
            if (owed_beats.size() == 0)
            begin
                report($sformatf("result beat %h with nothing outstanding", got));
                return;
            end
            want = owed_beats.pop_front();
            beats_checked++;
            compare_field("status", got.status, want.status);
            compare_field("is_report", got.is_report, want.is_report);
            compare_field("report_modifiers", got.report_modifiers, want.report_modifiers);
            compare_field("slot0", got.slot0, want.slot0);
            compare_field("slot1", got.slot1, want.slot1);
            compare_field("slot2", got.slot2, want.slot2);
            compare_field("slot3", got.slot3, want.slot3);
            compare_field("slot4", got.slot4, want.slot4);
            compare_field("slot5", got.slot5, want.slot5);
            compare_field("more_pending", got.more_pending, want.more_pending);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    hpkt_in_t         cmd;
    logic             cfg_wr_en;
    logic [7:0]       cfg_wr_data;
    hpkt_out_t        result;
    logic             strobe;
    key_table_checker table_chk;
    int               none_settings;

    hid_pressed_key_table #(
        .MAX_KEYS (TABLE_KEYS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result),
        .strobe      (strobe)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result beats are checked as they are strobed
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            table_chk.check_beat(result);
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d beats outstanding", table_chk.owed_beats.size());
        $display("TEST FAILED");
        $finish;
    end

    // issue one command beat, entered and left at a falling edge
    task automatic issue(input logic [1:0] m, input logic [7:0] k, input logic [7:0] mods,
                         input int gap);
        hpkt_in_t c;
        c.mode = m;
        c.key_code = k;
        c.modifier_bits = mods;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        table_chk.apply_command(c);
        @(negedge clk);
    endtask

    // drop start and let every owed beat arrive before touching the register
    task automatic wait_idle();
        start <= 1'b0;
        while (table_chk.owed_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_none_code(input logic [7:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        table_chk.none_code = v;
        none_settings++;
    endtask

    // stimulus
    initial
    begin
        logic [7:0] pool [10];
        logic [1:0] m;
        logic [7:0] k;
        int         gap;
        int         pick;
        int         waited;
        bit         idle_on;

        table_chk = new();
        none_settings = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty report, absent release, extremes, repeats, full table
        issue(MODE_REPORT, 8'h00, 8'hFF, 0);
        issue(MODE_RELEASE, 8'h04, 8'h00, 0);
        issue(MODE_PRESS, 8'h00, 8'h00, 0);
        issue(MODE_PRESS, 8'hFF, 8'h00, 0);
        issue(MODE_PRESS, 8'hFF, 8'h00, 1);
        issue(MODE_TAP, 8'h10, 8'h00, 0);
        issue(MODE_TAP, 8'h10, 8'h00, 0);
        issue(MODE_PRESS, 8'h11, 8'h00, 2);
        issue(MODE_PRESS, 8'h12, 8'h00, 0);
        issue(MODE_PRESS, 8'h13, 8'h00, 0);
        issue(MODE_PRESS, 8'h14, 8'h00, 0);
        issue(MODE_TAP, 8'h15, 8'h00, 0);
        issue(MODE_REPORT, 8'h00, 8'hA5, 0);
        issue(MODE_REPORT, 8'h00, 8'h00, 3);
        issue(MODE_REPORT, 8'h00, 8'h5A, 0);
        issue(MODE_TAP, 8'h11, 8'h00, 0);
        issue(MODE_PRESS, 8'h11, 8'h00, 0);
        issue(MODE_RELEASE, 8'hFF, 8'h00, 0);
        issue(MODE_RELEASE, 8'h13, 8'h00, 0);
        issue(MODE_RELEASE, 8'h13, 8'h00, 0);

        // none code at its top value, then a press of it
        write_none_code(8'hFF);
        issue(MODE_PRESS, 8'hFF, 8'h00, 0);
        issue(MODE_PRESS, 8'hFF, 8'h00, 0);
        issue(MODE_REPORT, 8'h00, 8'h81, 0);

        // repeat count driven into saturation
        for (int i = 0; i < 258; i++)
            issue(MODE_TAP, 8'h2A, 8'($urandom_range(0, 255)), 0);
        issue(MODE_REPORT, 8'h00, 8'h3C, 0);
        issue(MODE_REPORT, 8'h00, 8'hC3, 0);
        issue(MODE_RELEASE, 8'h2A, 8'h00, 0);

        // random phases, each with its own key pool and none code
        for (int phase = 0; phase < 6; phase++)
        begin
            foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
            case (phase)
                0: write_none_code(8'h00);
                1: write_none_code(8'hFF);
                3: write_none_code(pool[0]);
                default: write_none_code(8'($urandom_range(0, 255)));
            endcase
            idle_on = 1'b0;
            for (int n = 0; n < 170; n++)
            begin
                if (n % 40 == 0)
                    idle_on = (phase != 5) && ($urandom_range(0, 2) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    // well formed traffic on a small set of keys
                    k = pool[$urandom_range(0, 9)];
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                        m = MODE_PRESS;
                    else if (pick < 60)
                        m = MODE_RELEASE;
                    else if (pick < 80)
                        m = MODE_TAP;
                    else
                        m = MODE_REPORT;
                end
                else
                begin
                    m = 2'($urandom_range(0, 3));
                    k = 8'($urandom_range(0, 255));
                end
                gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
                issue(m, k, 8'($urandom_range(0, 255)), gap);
            end
        end

        // drain
        start <= 1'b0;
        waited = 0;
        while (table_chk.owed_beats.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        while (table_chk.owed_beats.size() != 0)
        begin
            table_chk.report($sformatf("beat %h never arrived",
                                       table_chk.owed_beats.pop_front()));
        end

        $display("covered %0d press, %0d release, %0d tap, %0d report commands; %0d beats",
                 table_chk.mode_hits[MODE_PRESS], table_chk.mode_hits[MODE_RELEASE],
                 table_chk.mode_hits[MODE_TAP], table_chk.mode_hits[MODE_REPORT],
                 table_chk.beats_checked);
        $display("full table %0d, saturated taps %0d, two-beat reports %0d, none codes %0d",
                 table_chk.full_hits, table_chk.saturated_hits,
                 table_chk.two_beat_reports, none_settings);
        if (table_chk.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
